FILE: src/psq_pkg.sv
package psq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int CODE_W  = 8;
    localparam int SENDS_W = 4;
    localparam int WAIT_W  = 16;
    localparam int QCNT_W  = 6;
    localparam int CFG_W   = 16;
    localparam int CFGI_W  = 2;

    localparam logic [1:0] MODE_ENQUEUE = 2'd0;
    localparam logic [1:0] MODE_TICK    = 2'd1;
    localparam logic [1:0] MODE_ACK     = 2'd2;

    localparam logic [CFGI_W-1:0] CFG_REQUEST_CODE  = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_REQUEST_SENDS = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_OTHER_SENDS   = 2'd2;
    localparam logic [CFGI_W-1:0] CFG_WAIT_TICKS    = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [CODE_W-1:0] packet_code;
    } t_in_item;

    typedef struct packed {
        logic              send_valid;
        logic [CODE_W-1:0] send_code;
        logic              enqueue_dropped;
        logic [QCNT_W-1:0] queue_count;
    } t_out_item;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [SENDS_W-1:0] sends;
    } t_entry;

    typedef struct packed {
        logic [CODE_W-1:0]  request_code;
        logic [SENDS_W-1:0] request_sends;
        logic [SENDS_W-1:0] other_sends;
        logic [WAIT_W-1:0]  wait_ticks;
    } t_cfg;

    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry wdata;
    } t_fifo_ctl;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             full;
        logic             empty;
        t_entry           head;
    } t_fifo_stat;

endpackage

FILE: src/packet_send_queue_with_retry_unit.sv
// Channel      Direction  Handshake                      Payload
// command      in         start high, busy low           i_item (mode, packet_code)
// result       out        o_result_valid, one cycle      o_result (send, drop, count)
// config       in         i_cfg_valid and o_cfg_ready    i_cfg_index, i_cfg_data
//
// One item is taken every clock cycle; busy is never raised.
// The result of an item appears on o_result in the cycle after it is taken, for one cycle.
// The rate is set by the single pass from the queue head and retry state to the result register.
// Reset is synchronous and active low; it empties the queue and expires the wait counter.
// The receiver cannot stall, so no result is ever held back.
module packet_send_queue_with_retry_unit
    import psq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_item          i_item,
    output logic              o_result_valid,
    output t_out_item         o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFGI_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic       accept;
    t_cfg       cfg;
    t_fifo_ctl  fifo_ctl;
    t_fifo_stat fifo_stat;
    t_out_item  n_result;
    t_out_item  r_result;
    logic       r_result_valid;

    // Every item finishes in the cycle it is taken, so the block never stalls.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    psq_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The queue holds code and send count pairs; its head is always visible.
    psq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fifo_ctl),
        .o_stat  (fifo_stat)
    );

    // The retry unit decides enqueue, drop, resend or dequeue for each item,
    // and keeps the current packet, its remaining sends and the wait counter.
    psq_retry u_retry (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .i_cfg    (cfg),
        .i_stat   (fifo_stat),
        .o_ctl    (fifo_ctl),
        .o_result (n_result)
    );

    // The result register carries no reset; only its strobe is cleared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

    // A result only ever follows an item taken in the cycle before.
    a_result_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start))
        else $error("result without a preceding item");

    // A dropped enqueue can only happen with a full queue and never sends.
    a_drop_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.enqueue_dropped) |->
        (o_result.queue_count == QCNT_W'(QUEUE_DEPTH) && !o_result.send_valid))
        else $error("drop reported while queue not full");

    // The reported count never exceeds the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.queue_count <= QCNT_W'(QUEUE_DEPTH)))
        else $error("queue count beyond depth");

    // A send code of nonzero value requires a send.
    a_code_needs_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.send_valid) |-> (o_result.send_code == '0))
        else $error("send code without a send");

endmodule

FILE: src/psq_cfg_regs.sv
module psq_cfg_regs
    import psq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [CFGI_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.request_code  <= CODE_W'(0);
            r_cfg.request_sends <= SENDS_W'(3);
            r_cfg.other_sends   <= SENDS_W'(1);
            r_cfg.wait_ticks    <= WAIT_W'(50);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REQUEST_CODE:  r_cfg.request_code  <= i_cfg_data[CODE_W-1:0];
                CFG_REQUEST_SENDS: r_cfg.request_sends <= i_cfg_data[SENDS_W-1:0];
                CFG_OTHER_SENDS:   r_cfg.other_sends   <= i_cfg_data[SENDS_W-1:0];
                CFG_WAIT_TICKS:    r_cfg.wait_ticks    <= i_cfg_data[WAIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/psq_fifo.sv
module psq_fifo
    import psq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fifo_ctl  i_ctl,
    output t_fifo_stat o_stat
);

    t_entry           r_slot [QUEUE_DEPTH];
    t_entry           r_head_entry;
    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] n_head;
    logic [IDX_W-1:0] n_tail;
    logic [CNT_W-1:0] n_count;

    // Pointers wrap explicitly so that depths other than a power of two work.
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctl.push) begin
            n_tail  = (r_tail == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end
        if (i_ctl.pop) begin
            n_head  = (r_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // The head entry is registered from the next head address. A push
    // into an empty queue writes the slot that becomes the head, so the new
    // entry is forwarded straight into the head register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_slot[r_tail] <= i_ctl.wdata;
        end
        if (i_ctl.push && (r_tail == n_head)) begin
            r_head_entry <= i_ctl.wdata;
        end else begin
            r_head_entry <= r_slot[n_head];
        end
    end

    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count >= CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.head  = r_head_entry;

endmodule

FILE: src/psq_retry.sv
module psq_retry
    import psq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_in_item   i_item,
    input  t_cfg       i_cfg,
    input  t_fifo_stat i_stat,
    output t_fifo_ctl  o_ctl,
    output t_out_item  o_result
);

    logic [CODE_W-1:0]  r_cur_code;
    logic [SENDS_W-1:0] r_sends_left;
    logic [WAIT_W-1:0]  r_wait;
    logic [CODE_W-1:0]  n_cur_code;
    logic [SENDS_W-1:0] n_sends_left;
    logic [WAIT_W-1:0]  n_wait;
    logic [CNT_W-1:0]   count_after;

    always_comb begin
        n_cur_code   = r_cur_code;
        n_sends_left = r_sends_left;
        n_wait       = r_wait;
        o_ctl        = '0;
        o_ctl.wdata.code  = i_item.packet_code;
        o_ctl.wdata.sends = (i_item.packet_code == i_cfg.request_code) ?
                            i_cfg.request_sends : i_cfg.other_sends;
        o_result     = '0;

        if (i_accept) begin
            case (i_item.mode)
                MODE_ENQUEUE: begin
                    if (i_stat.full) begin
                        o_result.enqueue_dropped = 1'b1;
                    end else begin
                        o_ctl.push = 1'b1;
                    end
                end
                MODE_TICK: begin
                    if (r_wait != '0) begin
                        n_wait = r_wait - 1'b1;
                    end else begin
                        if (r_sends_left == '0) begin
                            if (!i_stat.empty) begin
                                o_ctl.pop  = 1'b1;
                                n_cur_code = i_stat.head.code;
                                // A zero send count is sent once and stays zero.
                                n_sends_left = (i_stat.head.sends == '0) ?
                                               '0 : i_stat.head.sends - 1'b1;
                                o_result.send_valid = 1'b1;
                                o_result.send_code  = i_stat.head.code;
                            end
                        end else begin
                            n_sends_left        = r_sends_left - 1'b1;
                            o_result.send_valid = 1'b1;
                            o_result.send_code  = r_cur_code;
                        end
                        n_wait = i_cfg.wait_ticks;
                    end
                end
                MODE_ACK: begin
                    if (i_item.packet_code == r_cur_code) begin
                        n_sends_left = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        count_after = i_stat.count;
        if (o_ctl.push) begin
            count_after = i_stat.count + 1'b1;
        end
        if (o_ctl.pop) begin
            count_after = i_stat.count - 1'b1;
        end
        o_result.queue_count = QCNT_W'(count_after);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_code   <= '0;
            r_sends_left <= '0;
            r_wait       <= '0;
        end else begin
            r_cur_code   <= n_cur_code;
            r_sends_left <= n_sends_left;
            r_wait       <= n_wait;
        end
    end

endmodule

FILE: dv/tb_top.sv
module tb_top;
    import psq_pkg::*;

    // Mode three has no meaning in the block; it must be ignored.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Cycles without any accepted item, result or register write before the run is
    // declared hung. The longest quiet stretch in a correct run is a sender gap
    // or the short pause before a register write.
    localparam int STALL_LIMIT = 500;

    // The scoreboard keeps its own copy of the queue, the retry state and the
    // registers. Each accepted command item is played through that copy, and the
    // report the block should give for it is queued. Each report from the block
    // is then checked against the oldest queued one.
    class send_queue_scoreboard;
        t_entry    slots[QUEUE_DEPTH];
        int        head_ptr;
        int        tail_ptr;
        int        fill;
        logic [CODE_W-1:0]  active_code;
        logic [SENDS_W-1:0] retries_left;
        logic [WAIT_W-1:0]  wait_left;
        t_cfg      regs;
        t_out_item expected_reports[$];
        int        error_count;

        function new();
            head_ptr     = 0;
            tail_ptr     = 0;
            fill         = 0;
            active_code  = '0;
            retries_left = '0;
            wait_left    = '0;
            regs.request_code  = 8'd0;
            regs.request_sends = 4'd3;
            regs.other_sends   = 4'd1;
            regs.wait_ticks    = 16'd50;
            error_count  = 0;
        endfunction

        function void write_register(logic [CFGI_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                CFG_REQUEST_CODE:  regs.request_code  = data[CODE_W-1:0];
                CFG_REQUEST_SENDS: regs.request_sends = data[SENDS_W-1:0];
                CFG_OTHER_SENDS:   regs.other_sends   = data[SENDS_W-1:0];
                CFG_WAIT_TICKS:    regs.wait_ticks    = data[WAIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_command(t_in_item cmd);
            t_out_item rep;
            t_entry    e;
            rep = '0;
            case (cmd.mode)
                MODE_ENQUEUE: begin
                    if (fill >= QUEUE_DEPTH) begin
                        rep.enqueue_dropped = 1'b1;
                    end else begin
                        e.code  = cmd.packet_code;
                        e.sends = (cmd.packet_code == regs.request_code) ?
                                  regs.request_sends : regs.other_sends;
                        slots[tail_ptr] = e;
                        tail_ptr = (tail_ptr + 1) % QUEUE_DEPTH;
                        fill++;
                    end
                end
                MODE_TICK: begin
                    if (wait_left != '0) begin
                        wait_left--;
                    end else begin
                        if (retries_left == '0) begin
                            if (fill != 0) begin
                                e = slots[head_ptr];
                                head_ptr = (head_ptr + 1) % QUEUE_DEPTH;
                                fill--;
                                active_code  = e.code;
                                retries_left = e.sends;
                                // A zero send count still sends once and does not wrap.
                                if (retries_left != '0) retries_left--;
                                rep.send_valid = 1'b1;
                                rep.send_code  = active_code;
                            end
                        end else begin
                            retries_left--;
                            rep.send_valid = 1'b1;
                            rep.send_code  = active_code;
                        end
                        wait_left = regs.wait_ticks;
                    end
                end
                MODE_ACK: begin
                    if (cmd.packet_code == active_code) retries_left = '0;
                end
                default: ;
            endcase
            rep.queue_count = QCNT_W'(fill);
            expected_reports.push_back(rep);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_reports.size() == 0) begin
                $error("report with nothing expected: %p", got);
                error_count++;
                return;
            end
            want = expected_reports.pop_front();
            if (got.send_valid !== want.send_valid) begin
                $error("send_valid: expected %0d, actual %0d", want.send_valid, got.send_valid);
                error_count++;
            end
            if (got.send_code !== want.send_code) begin
                $error("send_code: expected 0x%0h, actual 0x%0h", want.send_code, got.send_code);
                error_count++;
            end
            if (got.enqueue_dropped !== want.enqueue_dropped) begin
                $error("enqueue_dropped: expected %0d, actual %0d",
                       want.enqueue_dropped, got.enqueue_dropped);
                error_count++;
            end
            if (got.queue_count !== want.queue_count) begin
                $error("queue_count: expected %0d, actual %0d", want.queue_count, got.queue_count);
                error_count++;
            end
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    t_in_item          i_item      = '0;
    logic              i_cfg_valid = 1'b0;
    logic [CFGI_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data  = '0;
    logic              busy;
    logic              o_result_valid;
    t_out_item         o_result;
    logic              o_cfg_ready;

    send_queue_scoreboard tracker = new();

    // Items left in the current sender burst; a random gap follows most bursts.
    int burst_left = 1;
    int stall_cycles = 0;

    always #4 i_clk = ~i_clk;

    packet_send_queue_with_retry_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // The receiver cannot hold reports off, so every strobe is taken at the edge
    // that ends its cycle. All outputs are sampled before the edge's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            tracker.check_result(o_result);
        end
    end

    // Watchdog: any accepted item, report or register write counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Drives one command item and holds it until the block takes it. The caller is
    // always at a rising edge, and start is left high so that a burst goes on
    // without a bubble. At the end of most bursts start drops for a random gap.
    task automatic issue(input t_in_item cmd);
        start  <= 1'b1;
        i_item <= cmd;
        do @(posedge i_clk); while (busy);
        tracker.note_command(cmd);
        burst_left--;
        if (burst_left <= 0) begin
            // Some bursts are long, so that stretches without any idling occur too.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) :
                                                       $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    task automatic issue_fields(input logic [1:0] mode, input logic [CODE_W-1:0] code);
        t_in_item cmd;
        cmd.mode        = mode;
        cmd.packet_code = code;
        issue(cmd);
    endtask

    // Brings the block to rest: no command pending and every report received.
    // Each item gives its report in the cycle after it is taken, so a short pause suffices.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.expected_reports.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFGI_W-1:0] index, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_register(index, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes all four registers. The unused upper data bits of the narrow
    // registers carry random junk, which the block must ignore.
    task automatic configure(input logic [CODE_W-1:0] req_code, input logic [SENDS_W-1:0] req_n,
                             input logic [SENDS_W-1:0] oth_n, input logic [WAIT_W-1:0] wait_n);
        logic [CFG_W-1:0] word;
        drain();
        word = CFG_W'($urandom);
        word[CODE_W-1:0] = req_code;
        write_reg(CFG_REQUEST_CODE, word);
        word = CFG_W'($urandom);
        word[SENDS_W-1:0] = req_n;
        write_reg(CFG_REQUEST_SENDS, word);
        word = CFG_W'($urandom);
        word[SENDS_W-1:0] = oth_n;
        write_reg(CFG_OTHER_SENDS, word);
        write_reg(CFG_WAIT_TICKS, wait_n);
    endtask

    // Codes lean toward the request code so that both send counts are used,
    // and toward a few fixed values so that acknowledgments often match.
    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return tracker.regs.request_code;
        if (r < 6) begin
            case ($urandom_range(0, 3))
                0: return 8'h00;
                1: return 8'hFF;
                2: return 8'h5A;
                default: return 8'hA5;
            endcase
        end
        return CODE_W'($urandom);
    endfunction

    // Random traffic built from short well-formed runs: bursts of enqueues,
    // runs of ticks that drain the queue and retry, and acknowledgments that
    // mostly name the packet in flight. A small share is noise.
    task automatic run_traffic(input int n_items);
        int issued;
        int kind;
        int len;
        issued = 0;
        while (issued < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                len = (kind < 5) ? $urandom_range(20, 40) : $urandom_range(1, 10);
                repeat (len) issue_fields(MODE_ENQUEUE, pick_code());
                issued += len;
            end else if (kind < 75) begin
                len = $urandom_range(1, 20);
                repeat (len) issue_fields(MODE_TICK, CODE_W'($urandom));
                issued += len;
            end else if (kind < 90) begin
                if ($urandom_range(0, 3) != 0) begin
                    issue_fields(MODE_ACK, tracker.active_code);
                end else begin
                    issue_fields(MODE_ACK, pick_code());
                end
                issued++;
            end else begin
                if ($urandom_range(0, 1) == 0) begin
                    issue_fields(MODE_UNUSED, CODE_W'($urandom));
                end else begin
                    issue_fields(2'($urandom), CODE_W'($urandom));
                end
                issued++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. The wait counter comes out of reset expired, so with a
        // zero reload every tick below is an expired tick. The largest request
        // count and a zero count for other codes are both in use here.
        configure(8'hFF, 4'd15, 4'd0, 16'd0);
        // Expired tick on an empty queue: nothing is sent.
        issue_fields(MODE_TICK, 8'h00);
        issue_fields(MODE_ENQUEUE, 8'hFF);
        issue_fields(MODE_ENQUEUE, 8'h00);
        issue_fields(MODE_ENQUEUE, 8'h5A);
        // Unused mode and acknowledgments with nothing in flight.
        issue_fields(MODE_UNUSED, 8'hA5);
        issue_fields(MODE_ACK, 8'h33);
        issue_fields(MODE_ACK, 8'h00);
        // The request packet goes out and is retried, then acknowledged.
        issue_fields(MODE_TICK, 8'hFF);
        issue_fields(MODE_TICK, 8'h00);
        issue_fields(MODE_ACK, 8'hFF);
        // Zero-count packets go out once each, then the queue runs dry.
        issue_fields(MODE_TICK, 8'h00);
        issue_fields(MODE_TICK, 8'h00);
        issue_fields(MODE_TICK, 8'h00);
        issue_fields(MODE_TICK, 8'hFF);
        run_traffic(180);

        configure(CODE_W'($urandom), 4'd3, 4'd1, 16'd1);
        run_traffic(190);
        configure(8'h00, 4'd1, 4'd15, 16'd2);
        run_traffic(190);
        // The reset values again, with the slower retry interval.
        configure(8'h00, 4'd3, 4'd1, 16'd50);
        run_traffic(190);
        configure(CODE_W'($urandom), SENDS_W'($urandom_range(1, 15)),
                  SENDS_W'($urandom_range(1, 15)), 16'd3);
        run_traffic(190);
        configure(8'h5A, 4'd2, 4'd2, 16'd0);
        run_traffic(190);
        // The longest interval comes last, since the counter it loads would hold
        // off sends for the rest of the run; the queue fills and drops here.
        configure(8'hA5, 4'd15, 4'd15, 16'hFFFF);
        run_traffic(100);

        drain();
        if (tracker.error_count == 0 && tracker.expected_reports.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
